>>> src/scs_pkg.sv
// Package for the sincos_approx_f32 block: binary32 constants, sideband type,
// and the round-to-nearest-even multiply, add and pack functions.
// No dependencies.
package scs_pkg;

    localparam logic [31:0] QNAN   = 32'h7FC0_0000;
    localparam logic [31:0] C_2PI  = 32'h3F22_F983;
    localparam logic [31:0] C_PIO2 = 32'h3FC9_0FDB;
    localparam logic [31:0] C_ONE  = 32'h3F80_0000;
    localparam logic [31:0] S_C0   = 32'hB94C_A644;
    localparam logic [31:0] S_C1   = 32'h3C08_83D0;
    localparam logic [31:0] S_C2   = 32'hBE2A_AAA4;
    localparam logic [31:0] K_C0   = 32'hBAB6_09A5;
    localparam logic [31:0] K_C1   = 32'h3D2A_AA85;
    localparam logic [31:0] K_C2   = 32'hBEFF_FFFB;
    localparam logic [31:0] BIG_T  = 32'h4B00_0000;

    typedef struct packed {
        logic [1:0] quad;
        logic       nan_in;
    } t_side;

    // value = m * 2^e, rounded to nearest even
    function automatic logic [31:0] fp_pack(input logic s, input logic [49:0] m,
                                            input logic signed [11:0] e);
        logic [5:0]         lz;
        logic [49:0]        mn;
        logic signed [11:0] be;
        logic signed [11:0] shn;
        logic [5:0]         sh;
        logic [100:0]       ext;
        logic               st;
        logic               rnd;
        logic [30:0]        body;
        lz = '0;
        for (int i = 0; i < 50; i++) begin
            if (m[i]) lz = 6'(49 - i);
        end
        if (m == '0) return {s, 31'b0};
        mn = m << lz;
        be = e - $signed({6'b0, lz}) + 12'sd176;
        if (be > 12'sd254) return {s, 8'hFF, 23'b0};
        st = 1'b0;
        if (be < 12'sd1) begin
            shn = 12'sd1 - be;
            sh  = (shn > 12'sd51) ? 6'd51 : shn[5:0];
            ext = {mn, 51'b0} >> sh;
            mn  = ext[100:51];
            st  = |ext[50:0];
            be  = '0;
        end
        st   = st | (|mn[24:0]);
        rnd  = mn[25] & (st | mn[26]);
        body = {be[7:0], mn[48:26]} + 31'(rnd);
        return {s, body};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        na, nb, ia, ib, za, zb, s;
        logic [23:0] ma, mb;
        logic [7:0]  ea, eb;
        logic [47:0] p;
        na = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        za = (a[30:0] == '0);
        zb = (b[30:0] == '0);
        s  = a[31] ^ b[31];
        if (na || nb || (ia && zb) || (ib && za)) return QNAN;
        if (ia || ib) return {s, 8'hFF, 23'b0};
        ma = {a[30:23] != '0, a[22:0]};
        mb = {b[30:23] != '0, b[22:0]};
        ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
        p  = ma * mb;
        return fp_pack(s, {2'b0, p},
                       $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd300);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        na, nb, ia, ib, sx, sy, stk, s;
        logic [31:0] x, y;
        logic [23:0] mx, my;
        logic [7:0]  ex, ey, d;
        logic [49:0] av, bf, bs, sum;
        na = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        if (na || nb || (ia && ib && (a[31] != b[31]))) return QNAN;
        if (ia) return a;
        if (ib) return b;
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        sx = x[31];
        sy = y[31];
        mx = {x[30:23] != '0, x[22:0]};
        my = {y[30:23] != '0, y[22:0]};
        ex = (x[30:23] == '0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == '0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        av = {1'b0, mx, 25'b0};
        bf = {1'b0, my, 25'b0};
        if (d >= 8'd50) begin
            bs  = '0;
            stk = |my;
        end else begin
            bs  = bf >> d;
            stk = |(bf & ((50'b1 << d) - 50'b1));
        end
        bs[0] = bs[0] | stk;
        sum = (sx == sy) ? av + bs : av - bs;
        s   = (sum == '0) ? (sx & sy) : sx;
        return fp_pack(s, sum, $signed({4'b0, ex}) - 12'sd175);
    endfunction

endpackage

>>> src/scs_reduce.sv
// Argument reduction pipeline, five stages: t = x*2/pi, rounding to n,
// n as binary32, n*pi/2, r = x - n*pi/2. Depends on scs_pkg.
module scs_reduce (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_x,
    output logic [31:0]          o_r,
    output scs_pkg::t_side       o_side
);

    logic [31:0]    r1_x, r1_t;
    logic           r1_nan;
    logic [31:0]    r2_x, r2_t;
    logic [23:0]    r2_k;
    logic           r2_big;
    scs_pkg::t_side r2_side;
    logic [31:0]    r3_x, r3_n;
    scs_pkg::t_side r3_side;
    logic [31:0]    r4_x, r4_p;
    scs_pkg::t_side r4_side;
    logic [31:0]    r5_r;
    scs_pkg::t_side r5_side;

    logic [23:0] sig;
    logic [7:0]  et;
    logic [4:0]  sh;
    logic [23:0] kt;
    logic        half;
    logic        big;
    logic [23:0] n_k;
    logic [1:0]  mag2;

    always_comb begin
        et   = r1_t[30:23];
        sig  = {1'b1, r1_t[22:0]};
        big  = (r1_t[30:0] >= scs_pkg::BIG_T[30:0]);
        sh   = 5'(8'd150 - et);
        kt   = sig >> sh;
        half = sig[5'(sh - 5'd1)];
        if (big || et < 8'd126) begin
            n_k = '0;
        end else begin
            n_k = kt + 24'(half);
        end
        if (big) begin
            if (et == 8'd150) begin
                mag2 = sig[1:0];
            end else if (et == 8'd151) begin
                mag2 = {sig[0], 1'b0};
            end else begin
                mag2 = 2'd0;
            end
        end else begin
            mag2 = n_k[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x   <= i_x;
            r1_t   <= scs_pkg::fp_mul(i_x, scs_pkg::C_2PI);
            r1_nan <= (i_x[30:23] == 8'hFF);

            r2_x           <= r1_x;
            r2_t           <= r1_t;
            r2_k           <= n_k;
            r2_big         <= big;
            r2_side.nan_in <= r1_nan;
            r2_side.quad   <= r1_t[31] ? 2'(2'd0 - mag2) : mag2;

            r3_x    <= r2_x;
            r3_n    <= r2_big ? r2_t : scs_pkg::fp_pack(r2_t[31], {26'b0, r2_k}, 12'sd0);
            r3_side <= r2_side;

            r4_x    <= r3_x;
            r4_p    <= scs_pkg::fp_mul(r3_n, scs_pkg::C_PIO2);
            r4_side <= r3_side;

            r5_r    <= scs_pkg::fp_add(r4_x, {~r4_p[31], r4_p[30:0]});
            r5_side <= r4_side;
        end
    end

    assign o_r    = r5_r;
    assign o_side = r5_side;

endmodule

>>> src/scs_poly.sv
// Polynomial pipeline, eight stages: r^2, then Horner for sine and cosine
// in parallel, one multiply or add per stage. Depends on scs_pkg.
module scs_poly (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_r,
    input  scs_pkg::t_side       i_side,
    output logic [31:0]          o_sin,
    output logic [31:0]          o_cos,
    output scs_pkg::t_side       o_side
);

    logic [31:0]    r6_r, r6_r2;
    logic [31:0]    r7_r, r7_r2, r7_s, r7_c;
    logic [31:0]    r8_r, r8_r2, r8_s, r8_c;
    logic [31:0]    r9_r, r9_r2, r9_s, r9_c;
    logic [31:0]    r10_r, r10_r2, r10_s, r10_c;
    logic [31:0]    r11_r, r11_s, r11_c;
    logic [31:0]    r12_r, r12_s, r12_c;
    logic [31:0]    r13_s, r13_c;
    scs_pkg::t_side r6_sd, r7_sd, r8_sd, r9_sd, r10_sd, r11_sd, r12_sd, r13_sd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_r  <= i_r;
            r6_r2 <= scs_pkg::fp_mul(i_r, i_r);
            r6_sd <= i_side;

            r7_r  <= r6_r;
            r7_r2 <= r6_r2;
            r7_s  <= scs_pkg::fp_mul(scs_pkg::S_C0, r6_r2);
            r7_c  <= scs_pkg::fp_mul(scs_pkg::K_C0, r6_r2);
            r7_sd <= r6_sd;

            r8_r  <= r7_r;
            r8_r2 <= r7_r2;
            r8_s  <= scs_pkg::fp_add(scs_pkg::S_C1, r7_s);
            r8_c  <= scs_pkg::fp_add(scs_pkg::K_C1, r7_c);
            r8_sd <= r7_sd;

            r9_r  <= r8_r;
            r9_r2 <= r8_r2;
            r9_s  <= scs_pkg::fp_mul(r8_s, r8_r2);
            r9_c  <= scs_pkg::fp_mul(r8_c, r8_r2);
            r9_sd <= r8_sd;

            r10_r  <= r9_r;
            r10_r2 <= r9_r2;
            r10_s  <= scs_pkg::fp_add(scs_pkg::S_C2, r9_s);
            r10_c  <= scs_pkg::fp_add(scs_pkg::K_C2, r9_c);
            r10_sd <= r9_sd;

            r11_r  <= r10_r;
            r11_s  <= scs_pkg::fp_mul(r10_s, r10_r2);
            r11_c  <= scs_pkg::fp_mul(r10_c, r10_r2);
            r11_sd <= r10_sd;

            r12_r  <= r11_r;
            r12_s  <= scs_pkg::fp_add(scs_pkg::C_ONE, r11_s);
            r12_c  <= scs_pkg::fp_add(scs_pkg::C_ONE, r11_c);
            r12_sd <= r11_sd;

            r13_s  <= scs_pkg::fp_mul(r12_r, r12_s);
            r13_c  <= r12_c;
            r13_sd <= r12_sd;
        end
    end

    assign o_sin  = r13_s;
    assign o_cos  = r13_c;
    assign o_side = r13_sd;

endmodule

>>> src/sincos_approx_f32.sv
// sincos_approx_f32: binary32 sine and cosine of one angle per item.
// Pipeline: 5 reduction stages, 8 polynomial stages, 1 output stage.
// Throughput one item per cycle; the whole pipe freezes while a valid output is stalled.
// Reset (synchronous, active low) clears the valid bits; payload is not reset.
// Depends on scs_pkg, scs_reduce and scs_poly.
module sincos_approx_f32 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_angle_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sine_bits,
    output logic [31:0] o_cosine_bits
);

    localparam int unsigned DEPTH = 14;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic             en;
    logic [31:0]      red_r;
    scs_pkg::t_side   red_side;
    logic [31:0]      p_sin, p_cos;
    scs_pkg::t_side   p_side;
    logic [31:0]      r_sin, r_cos;
    logic [31:0]      so, co;

    assign o_stall = r_vld[DEPTH-1] & i_stall;
    assign en      = ~o_stall;
    assign n_vld   = {r_vld[DEPTH-2:0], i_valid};

    scs_reduce u_reduce (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (i_angle_bits),
        .o_r    (red_r),
        .o_side (red_side)
    );

    scs_poly u_poly (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_r    (red_r),
        .i_side (red_side),
        .o_sin  (p_sin),
        .o_cos  (p_cos),
        .o_side (p_side)
    );

    always_comb begin
        case (p_side.quad)
            2'd1: begin
                so = p_cos;
                co = {~p_sin[31], p_sin[30:0]};
            end
            2'd2: begin
                so = {~p_sin[31], p_sin[30:0]};
                co = {~p_cos[31], p_cos[30:0]};
            end
            2'd3: begin
                so = {~p_cos[31], p_cos[30:0]};
                co = p_sin;
            end
            default: begin
                so = p_sin;
                co = p_cos;
            end
        endcase
        if (p_side.nan_in || (so[30:23] == 8'hFF && so[22:0] != '0)) so = scs_pkg::QNAN;
        if (p_side.nan_in || (co[30:23] == 8'hFF && co[22:0] != '0)) co = scs_pkg::QNAN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sin <= so;
            r_cos <= co;
        end
    end

    assign o_valid       = r_vld[DEPTH-1];
    assign o_sine_bits   = r_sin;
    assign o_cosine_bits = r_cos;

endmodule

>>> src/scs_chk.sv
// Port checker for sincos_approx_f32 and its bind statement.
// Depends on scs_pkg.
module scs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_sine_bits,
    input logic [31:0] o_cosine_bits
);

    a_sin_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sine_bits[30:23] == 8'hFF && o_sine_bits[22:0] != '0
        |-> o_sine_bits == scs_pkg::QNAN)
        else $error("sine NaN not canonical");

    a_cos_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cosine_bits[30:23] == 8'hFF && o_cosine_bits[22:0] != '0
        |-> o_cosine_bits == scs_pkg::QNAN)
        else $error("cosine NaN not canonical");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while pipe can drain");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sine_bits) && $stable(o_cosine_bits))
        else $error("stalled item changed");

endmodule

bind sincos_approx_f32 scs_chk u_scs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_sine_bits   (o_sine_bits),
    .o_cosine_bits (o_cosine_bits)
);

>>> dv/tb_sincos_approx_f32.sv
// Self-checking testbench for sincos_approx_f32: streams binary32 angles through the
// valid/stall handshake and compares sine and cosine against a bit-exact predictor.
// Depends on scs_pkg (constants) and the sincos_approx_f32 RTL.
module tb_sincos_approx_f32;

    typedef struct packed {
        logic [31:0] sine;
        logic [31:0] cosine;
    } t_pair;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_angle_bits;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_sine_bits;
    logic [31:0] o_cosine_bits;

    logic [31:0] angle_queue[$];
    t_pair       sincos_due[$];
    int          errors;
    int          cycles;
    int          items_in;
    int          send_gap;
    int          recv_gap;
    int          holdoff;
    bit          holdoff_done;
    bit          taken;

    sincos_approx_f32 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_angle_bits  (i_angle_bits),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sine_bits   (o_sine_bits),
        .o_cosine_bits (o_cosine_bits)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // round an exact or double-precision value to binary32, nearest even
    function automatic logic [31:0] round_to_f32(real v);
        logic [63:0] d;
        logic [63:0] full;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] kept;
        logic [63:0] body;
        int          fe;
        int          sh;
        d = $realtobits(v);
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 0) ? scs_pkg::QNAN : {d[63], 8'hFF, 23'b0};
        end
        if (d[62:52] == 11'h000) return {d[63], 31'b0};
        fe   = int'(d[62:52]) - 1023 + 127;
        full = {11'b0, 1'b1, d[51:0]};
        sh   = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 55) sh = 55;
        kept = full >> sh;
        rem  = full & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
        body = ((fe >= 1) ? (64'(fe - 1) << 23) : 64'd0) + kept;
        if (body >= 64'h7F80_0000) return {d[63], 8'hFF, 23'b0};
        return {d[63], body[30:0]};
    endfunction

    function automatic real f32_value(logic [31:0] b);
        real v;
        if (b[30:23] == 8'h00) begin
            v = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
            return b[31] ? -v : v;
        end
        if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
        return $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'b0});
    endfunction

    function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        return round_to_f32(f32_value(a) * f32_value(b));
    endfunction

    function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        return round_to_f32(f32_value(a) + f32_value(b));
    endfunction

    function automatic logic [31:0] nan_clean(logic [31:0] b);
        return (b[30:23] == 8'hFF && b[22:0] != 0) ? scs_pkg::QNAN : b;
    endfunction

    function automatic t_pair predict_sincos(logic [31:0] x);
        t_pair       res;
        logic [31:0] t;
        logic [31:0] a;
        logic [31:0] n;
        logic [31:0] r;
        logic [31:0] r2;
        logic [31:0] s;
        logic [31:0] c;
        logic [31:0] mag;
        logic [1:0]  quad;
        real         av;
        if (x[30:23] == 8'hFF) begin
            res.sine   = scs_pkg::QNAN;
            res.cosine = scs_pkg::QNAN;
            return res;
        end
        t  = f32_mul(x, scs_pkg::C_2PI);
        a  = {1'b0, t[30:0]};
        av = f32_value(a);
        if (a < scs_pkg::BIG_T) begin
            mag = $rtoi(av);
            if (av - real'(mag) >= 0.5) mag = mag + 1;
            n = round_to_f32(real'(mag));
            n[31] = t[31];
        end else begin
            n   = t;
            mag = (a < 32'h4E80_0000) ? $rtoi(av) : 32'd0;
        end
        quad = t[31] ? 2'(0 - mag) : mag[1:0];
        r  = f32_add(x, f32_mul(n, scs_pkg::C_PIO2) ^ 32'h8000_0000);
        r2 = f32_mul(r, r);
        s  = f32_add(scs_pkg::S_C1, f32_mul(scs_pkg::S_C0, r2));
        s  = f32_add(scs_pkg::S_C2, f32_mul(s, r2));
        s  = f32_add(scs_pkg::C_ONE, f32_mul(s, r2));
        s  = f32_mul(r, s);
        c  = f32_add(scs_pkg::K_C1, f32_mul(scs_pkg::K_C0, r2));
        c  = f32_add(scs_pkg::K_C2, f32_mul(c, r2));
        c  = f32_add(scs_pkg::C_ONE, f32_mul(c, r2));
        case (quad)
            2'd1: begin res.sine = c; res.cosine = s ^ 32'h8000_0000; end
            2'd2: begin res.sine = s ^ 32'h8000_0000; res.cosine = c ^ 32'h8000_0000; end
            2'd3: begin res.sine = c ^ 32'h8000_0000; res.cosine = s; end
            default: begin res.sine = s; res.cosine = c; end
        endcase
        res.sine   = nan_clean(res.sine);
        res.cosine = nan_clean(res.cosine);
        return res;
    endfunction

    function automatic int gap_length();
        if (cycles[10]) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender
    always @(negedge i_clk) begin
        logic        nxt_valid;
        logic [31:0] nxt_angle;
        nxt_valid = i_valid;
        nxt_angle = i_angle_bits;
        if (i_rst_n && (!i_valid || taken)) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
            end else if (angle_queue.size() > 0) begin
                nxt_valid = 1'b1;
                nxt_angle = angle_queue.pop_front();
                send_gap  = gap_length();
            end
        end
        i_valid      <= nxt_valid;
        i_angle_bits <= nxt_angle;
    end

    // receiver stall, with one long hold-off while the sender keeps offering
    always @(negedge i_clk) begin
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (!holdoff_done && items_in >= 500) begin
            holdoff_done = 1'b1;
            holdoff      = 300;
        end
        if (holdoff > 0) begin
            holdoff   = holdoff - 1;
            nxt_stall = 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap  = recv_gap - 1;
            nxt_stall = 1'b1;
        end else begin
            recv_gap = gap_length();
        end
        i_stall <= nxt_stall;
    end

    // monitor
    always @(posedge i_clk) begin
        t_pair want;
        taken = i_rst_n && i_valid && !o_stall;
        if (taken) begin
            sincos_due.push_back(predict_sincos(i_angle_bits));
            items_in = items_in + 1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (sincos_due.size() == 0) begin
                $error("unexpected item: sine %h cosine %h", o_sine_bits, o_cosine_bits);
                errors = errors + 1;
            end else begin
                want = sincos_due.pop_front();
                if (o_sine_bits !== want.sine) begin
                    $error("sine_bits expected %h got %h", want.sine, o_sine_bits);
                    errors = errors + 1;
                end
                if (o_cosine_bits !== want.cosine) begin
                    $error("cosine_bits expected %h got %h", want.cosine, o_cosine_bits);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] v;
        errors       = 0;
        cycles       = 0;
        items_in     = 0;
        send_gap     = 0;
        recv_gap     = 0;
        holdoff      = 0;
        holdoff_done = 1'b0;
        taken        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_angle_bits = '0;
        angle_queue = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001,
                        32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                        32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h3F49_0FDB,
                        32'hBF49_0FDB, 32'h3FC9_0FDB, 32'hBFC9_0FDB, 32'h4049_0FDB,
                        32'hBF80_0000, 32'h3F80_0000, 32'h4B49_0FDB, 32'h4C80_0000,
                        32'h4E80_0000, 32'h5015_02F9, 32'hC040_0000, 32'h42C8_0000,
                        32'hB380_0000};
        for (int i = 0; i < 2000; i++) begin
            v = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3, 4: v[30:23] = 8'($urandom_range(140, 160));
                default: v[30:23] = 8'($urandom_range(100, 139));
            endcase
            angle_queue.push_back(v);
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (angle_queue.size() == 0 && !i_valid && sincos_due.size() == 0);
        repeat (30) @(posedge i_clk);
        if (errors == 0 && sincos_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
src/scs_pkg.sv
src/scs_reduce.sv
src/scs_poly.sv
src/sincos_approx_f32.sv
src/scs_chk.sv
dv/tb_sincos_approx_f32.sv
